[src/cave_automaton_generation_macros.svh]
// Assertion macros shared by the cave automaton RTL.
`ifndef CAVE_AUTOMATON_GENERATION_MACROS_SVH
`define CAVE_AUTOMATON_GENERATION_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge outside of reset.
`define CAG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cave automaton assertion failed");
// Property checked on every rising edge, reset included.
`define CAG_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cave automaton assertion failed");
`else
`define CAG_ASSERT(label, prop)
`define CAG_ASSERT_RST(label, prop)
`endif

`endif

[src/cag_pkg.sv]
package cag_pkg;

  // Width of one row on the streaming interfaces.
  localparam int ROW_BITS = 64;
  // Largest number of cells in use per row.
  localparam int MAX_ROW_CELLS = 64;

  // Configuration register widths.
  localparam int WIDTH_BITS = 7;
  localparam int LIMIT_BITS = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEATH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BIRTH_LIMIT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RST   = 7'd64;
  localparam logic [LIMIT_BITS-1:0] DEATH_LIMIT_RST = 4'd3;
  localparam logic [LIMIT_BITS-1:0] BIRTH_LIMIT_RST = 4'd4;

  // Result queue sizing.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Popcount width for the eight neighbors of a cell.
  localparam int NBR_CNT_BITS = 4;

  typedef logic [ROW_BITS-1:0] row_t;

  // Rule settings handed to the row update.
  typedef struct packed {
    logic [WIDTH_BITS-1:0] row_width;
    logic [LIMIT_BITS-1:0] death_limit;
    logic [LIMIT_BITS-1:0] birth_limit;
  } rules_t;

  // One result transaction.
  typedef struct packed {
    row_t new_row;
    logic last_row;
  } result_t;

  // Up to two results enter the queue per cycle, first before second.
  typedef struct packed {
    logic    en0;
    logic    en1;
    result_t d0;
    result_t d1;
  } push_t;

endpackage

[src/cag_if.sv]
// Input channel: one grid row per transaction.
interface cag_in_if;
  logic          valid;
  logic          ready;
  cag_pkg::row_t row_cells;
  logic          frame_end;

  modport source (output valid, output row_cells, output frame_end, input ready);
  modport sink (input valid, input row_cells, input frame_end, output ready);
endinterface

// Result channel: one updated row per transaction.
interface cag_out_if;
  logic          valid;
  logic          ready;
  cag_pkg::row_t new_row;
  logic          last_row;

  modport source (output valid, output new_row, output last_row, input ready);
  modport sink (input valid, input new_row, input last_row, output ready);
endinterface

[src/cag_lane.sv]
// One cell of the automaton: counts wall neighbors and applies the rule.
module cag_lane (
  input  logic [7:0]                     nbr,
  input  logic                           center,
  input  logic [cag_pkg::LIMIT_BITS-1:0] death_limit,
  input  logic [cag_pkg::LIMIT_BITS-1:0] birth_limit,
  output logic                           next_cell
);

  logic [cag_pkg::NBR_CNT_BITS-1:0] walls;

  // Count the walls among the eight neighbors.
  always_comb begin
    walls = '0;
    for (int k = 0; k < 8; k++) begin
      walls = walls + cag_pkg::NBR_CNT_BITS'(nbr[k]);
    end
  end

  // A wall survives unless starved; an empty cell is born when crowded.
  assign next_cell = center ? !(walls < death_limit) : (walls > birth_limit);

endmodule

[src/cag_row_update.sv]
// Computes one updated row from the rows above, at and below it.
module cag_row_update (
  input  cag_pkg::row_t   above,
  input  cag_pkg::row_t   mid,
  input  cag_pkg::row_t   below,
  input  cag_pkg::rules_t rules,
  output cag_pkg::row_t   new_row
);

  localparam logic [cag_pkg::WIDTH_BITS-1:0] MaxCells =
    cag_pkg::WIDTH_BITS'(cag_pkg::MAX_ROW_CELLS);

  logic [cag_pkg::WIDTH_BITS-1:0] width_eff;
  cag_pkg::row_t                  used;
  logic [cag_pkg::ROW_BITS+1:0]   a_pad;
  logic [cag_pkg::ROW_BITS+1:0]   m_pad;
  logic [cag_pkg::ROW_BITS+1:0]   b_pad;
  cag_pkg::row_t                  lane_out;

  // Mask of cells in use; wider settings clamp to the maximum.
  always_comb begin
    width_eff = (rules.row_width > MaxCells) ? MaxCells : rules.row_width;
    for (int i = 0; i < cag_pkg::ROW_BITS; i++) begin
      used[i] = (cag_pkg::WIDTH_BITS'(i) < width_eff);
    end
  end

  // Unused cells and both row ends read as walls.
  assign a_pad = {1'b1, above | ~used, 1'b1};
  assign m_pad = {1'b1, mid | ~used, 1'b1};
  assign b_pad = {1'b1, below | ~used, 1'b1};

  // One lane per cell position.
  for (genvar i = 0; i < cag_pkg::ROW_BITS; i++) begin : g_lane
    cag_lane u_lane (
      .nbr         ({a_pad[i+2:i], m_pad[i+2], m_pad[i], b_pad[i+2:i]}),
      .center      (m_pad[i+1]),
      .death_limit (rules.death_limit),
      .birth_limit (rules.birth_limit),
      .next_cell   (lane_out[i])
    );
  end

  // Merge the lane results; cells not in use are zero.
  assign new_row = lane_out & used;

endmodule

[src/cag_out_fifo.sv]
// Small result queue that takes up to two results per cycle.
module cag_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  cag_pkg::push_t  push,
  output logic            room_two,
  cag_out_if.source       out_ch
);

  cag_pkg::result_t                mem_r [cag_pkg::FIFO_DEPTH];
  logic [cag_pkg::PTR_BITS-1:0]    wr_r;
  logic [cag_pkg::PTR_BITS-1:0]    wr_nxt;
  logic [cag_pkg::PTR_BITS-1:0]    rd_r;
  logic [cag_pkg::PTR_BITS-1:0]    rd_nxt;
  logic [cag_pkg::CNT_BITS-1:0]    cnt_r;
  logic [cag_pkg::CNT_BITS-1:0]    cnt_nxt;
  logic                            pop;

  assign pop = out_ch.valid & out_ch.ready;

  // Pointer and level updates.
  always_comb begin
    wr_nxt  = wr_r + cag_pkg::PTR_BITS'(push.en0) + cag_pkg::PTR_BITS'(push.en1);
    rd_nxt  = rd_r + cag_pkg::PTR_BITS'(pop);
    cnt_nxt = cnt_r + cag_pkg::CNT_BITS'(push.en0) + cag_pkg::CNT_BITS'(push.en1)
              - cag_pkg::CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage writes; the second result lands behind the first.
  always_ff @(posedge clk) begin
    if (push.en0) begin
      mem_r[wr_r] <= push.d0;
    end
    if (push.en1) begin
      mem_r[wr_r + cag_pkg::PTR_BITS'(1)] <= push.d1;
    end
  end

  // Head of queue drives the result channel.
  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.new_row  = mem_r[rd_r].new_row;
  assign out_ch.last_row = mem_r[rd_r].last_row;

  // Space for a full frame-end pair of results.
  assign room_two = (cnt_r <= cag_pkg::CNT_BITS'(cag_pkg::FIFO_DEPTH - 2));

endmodule

[src/cave_automaton_generation.sv]
// One generation of a binary cave automaton over a grid streamed one row per
// transaction, top row first, bit i of a row being cell i and 1 a wall. Each
// cell counts its eight wall neighbors (positions outside the grid or at and
// above row_width count as walls); a wall stays unless the count is below
// death_limit, an empty cell becomes a wall when the count exceeds
// birth_limit. Updated rows come out one row late: the row accepted with
// frame_end pushes out both the held row and itself, the latter marked
// last_row. A row is accepted every cycle; 64 parallel cell lanes (two row
// units for the frame-end pair) finish it in the accept cycle, and the result
// is available on the next cycle from a four-entry queue, which takes new rows
// while it has room for two results. Write configuration only while idle.
`include "cave_automaton_generation_macros.svh"

module cave_automaton_generation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cag_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cag_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  cag_in_if.sink                            in_ch,
  cag_out_if.source                         out_ch
);

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_ONE,
    HELD_TWO
  } held_t;

  held_t            held_r;
  cag_pkg::row_t    older_r;
  cag_pkg::row_t    newer_r;
  cag_pkg::rules_t  rules_r;
  cag_pkg::row_t    above0;
  cag_pkg::row_t    mid0;
  cag_pkg::row_t    below0;
  cag_pkg::row_t    upd0;
  cag_pkg::row_t    upd1;
  cag_pkg::push_t   push;
  logic             room_two;
  logic             in_acc;

  assign in_ch.ready = room_two;
  assign in_acc      = in_ch.valid & in_ch.ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rules_r.row_width   <= cag_pkg::ROW_WIDTH_RST;
      rules_r.death_limit <= cag_pkg::DEATH_LIMIT_RST;
      rules_r.birth_limit <= cag_pkg::BIRTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cag_pkg::CFG_ROW_WIDTH:   rules_r.row_width   <= cfg_wdata;
        cag_pkg::CFG_DEATH_LIMIT: rules_r.death_limit <= cfg_wdata[cag_pkg::LIMIT_BITS-1:0];
        cag_pkg::CFG_BIRTH_LIMIT: rules_r.birth_limit <= cfg_wdata[cag_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Neighborhood of the first result: the held row, or a lone bottom row.
  always_comb begin
    above0 = (held_r == HELD_TWO) ? older_r : '1;
    mid0   = (held_r == HELD_NONE) ? in_ch.row_cells : newer_r;
    below0 = (held_r == HELD_NONE) ? '1 : in_ch.row_cells;
  end

  cag_row_update u_upd0 (
    .above   (above0),
    .mid     (mid0),
    .below   (below0),
    .rules   (rules_r),
    .new_row (upd0)
  );

  // Second result: the bottom row with walls below it.
  cag_row_update u_upd1 (
    .above   (newer_r),
    .mid     (in_ch.row_cells),
    .below   ('1),
    .rules   (rules_r),
    .new_row (upd1)
  );

  // Results produced by the accepted transaction.
  always_comb begin
    push.en0         = in_acc & ((held_r != HELD_NONE) | in_ch.frame_end);
    push.en1         = in_acc & (held_r != HELD_NONE) & in_ch.frame_end;
    push.d0.new_row  = upd0;
    push.d0.last_row = (held_r == HELD_NONE);
    push.d1.new_row  = upd1;
    push.d1.last_row = 1'b1;
  end

  // Row window and held-row count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= HELD_NONE;
    end else if (in_acc) begin
      if (held_r == HELD_NONE) begin
        if (!in_ch.frame_end) begin
          held_r <= HELD_ONE;
        end
      end else begin
        held_r <= in_ch.frame_end ? HELD_NONE : HELD_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (held_r == HELD_NONE) begin
        newer_r <= in_ch.row_cells;
      end else begin
        older_r <= newer_r;
        newer_r <= in_ch.row_cells;
      end
    end
  end

  cag_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room_two (room_two),
    .out_ch   (out_ch)
  );

  // A frame end always empties the row window.
  `CAG_ASSERT(a_frame_end_clears, (in_acc && in_ch.frame_end) |=> (held_r == HELD_NONE))
  // A frame end always leaves a result ready to send.
  `CAG_ASSERT(a_frame_end_result, (in_acc && in_ch.frame_end) |=> out_ch.valid)
  // A first row of a frame is held, not emitted.
  `CAG_ASSERT(a_top_row_held,
    (in_acc && held_r == HELD_NONE && !in_ch.frame_end) |=> (held_r == HELD_ONE))
  // Reset leaves no result pending.
  `CAG_ASSERT_RST(a_reset_empty, !rst_n |=> !out_ch.valid)

endmodule
